[hw/rtl/ggs_pkg.sv]
// ----------------------------------------------------------------------------
// ggs_pkg
// shared widths, constants, types and the arctangent table of the steering block
// ----------------------------------------------------------------------------
package ggs_pkg;

	// number of cordic cells in the chain (8 to 24)
	localparam int CORDIC_STAGES = 16;

	// field widths
	localparam int POS_W  = 16;
	localparam int HEAD_W = 15;
	localparam int FWD_W  = 16;
	localparam int TURN_W = 14;
	localparam int CFG_IW = 8;
	localparam int CFG_DW = 16;

	// internal widths
	localparam int XW  = 28;  // cordic x / y, units of 2^-20
	localparam int ZW  = 24;  // cordic angle, units of 2^-20 rad
	localparam int EW  = 26;  // raw heading error
	localparam int DW  = 25;  // distance, units of 2^-20
	localparam int MW  = 22;  // heading error magnitude
	localparam int SIW = 5;   // cell index

	localparam logic signed [ZW-1:0] ANG_PI    = ZW'(3294199);
	localparam logic signed [EW-1:0] ERR_PI    = EW'(3294199);
	localparam logic signed [EW-1:0] ERR_2PI   = EW'(2 * 3294199);
	localparam logic [DW-1:0]        DIST_MIN  = DW'(104857);
	localparam logic [MW-1:0]        ERR_MIN   = MW'(209715);
	localparam logic [15:0]          INV_GAIN  = 16'd39797;
	localparam logic [MW-1:0]        TURN_RND  = MW'(128);

	// register reset values
	localparam logic [CFG_DW-1:0] GOAL_X_RST      = 16'd4096;
	localparam logic [CFG_DW-1:0] GOAL_Y_RST      = 16'd4096;
	localparam logic [CFG_DW-1:0] SPEED_GAIN_RST  = 16'd4096;
	localparam logic [CFG_DW-1:0] SPEED_LIMIT_RST = 16'd8192;

	typedef enum logic [CFG_IW-1:0] {
		REG_GOAL_X      = 8'd0,
		REG_GOAL_Y      = 8'd1,
		REG_SPEED_GAIN  = 8'd2,
		REG_SPEED_LIMIT = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_DW-1:0] goal_x;
		logic [CFG_DW-1:0] goal_y;
		logic [CFG_DW-1:0] speed_gain;
		logic [CFG_DW-1:0] speed_limit;
	} cfg_regs_t;

	// word handed from cell to cell
	typedef struct packed {
		logic signed [XW-1:0]     x;
		logic signed [XW-1:0]     y;
		logic signed [ZW-1:0]     z;
		logic signed [HEAD_W-1:0] head;
	} cordic_word_t;

	// distance and error magnitude after gain removal and wrap
	typedef struct packed {
		logic [DW-1:0] distance;
		logic [MW-1:0] mag;
	} steer_word_t;

	// round(atan(2^-i) * 2^20)
	function automatic logic [ZW-1:0] atan_lut(input logic [SIW-1:0] idx);
		logic [ZW-1:0] v;
		case (idx)
			5'd0:  v = ZW'(823550);
			5'd1:  v = ZW'(486170);
			5'd2:  v = ZW'(256879);
			5'd3:  v = ZW'(130396);
			5'd4:  v = ZW'(65451);
			5'd5:  v = ZW'(32757);
			5'd6:  v = ZW'(16383);
			5'd7:  v = ZW'(8192);
			5'd8:  v = ZW'(4096);
			5'd9:  v = ZW'(2048);
			5'd10: v = ZW'(1024);
			5'd11: v = ZW'(512);
			5'd12: v = ZW'(256);
			5'd13: v = ZW'(128);
			5'd14: v = ZW'(64);
			5'd15: v = ZW'(32);
			5'd16: v = ZW'(16);
			5'd17: v = ZW'(8);
			5'd18: v = ZW'(4);
			5'd19: v = ZW'(2);
			5'd20: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/ggs_pose_if.sv]
// ----------------------------------------------------------------------------
// ggs_pose_if
// pose channel: one word per robot pose
// ----------------------------------------------------------------------------
interface ggs_pose_if;
	logic                              valid;
	logic                              ready;
	logic [ggs_pkg::POS_W-1:0]         pose_x;
	logic [ggs_pkg::POS_W-1:0]         pose_y;
	logic signed [ggs_pkg::HEAD_W-1:0] heading;

	modport source (output valid, output pose_x, output pose_y, output heading, input ready);
	modport sink   (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface

[hw/rtl/ggs_cmd_if.sv]
// ----------------------------------------------------------------------------
// ggs_cmd_if
// command channel: one velocity command word per pose
// ----------------------------------------------------------------------------
interface ggs_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [ggs_pkg::FWD_W-1:0]  forward_speed;
	logic [ggs_pkg::TURN_W-1:0] turn_rate;

	modport source (output valid, output forward_speed, output turn_rate, input ready);
	modport sink   (input valid, input forward_speed, input turn_rate, output ready);
endinterface

[hw/rtl/ggs_cfg_if.sv]
// ----------------------------------------------------------------------------
// ggs_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface ggs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ggs_pkg::CFG_IW-1:0] index;
	logic [ggs_pkg::CFG_DW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ggs_front.sv]
// ----------------------------------------------------------------------------
// ggs_front
// goal minus pose, move into the right half-plane, register
// ----------------------------------------------------------------------------
module ggs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	ggs_pose_if.sink              pose,
	input  ggs_pkg::cfg_regs_t    cfg_regs,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ggs_pkg::cordic_word_t out_word
);
	localparam int POS_W_P = ggs_pkg::POS_W;
	localparam int PAD     = ggs_pkg::XW - ggs_pkg::POS_W - 1 - 8;

	logic                      valid_q;
	ggs_pkg::cordic_word_t     word_q;
	ggs_pkg::cordic_word_t     nxt;
	logic signed [POS_W_P:0]   dx;
	logic signed [POS_W_P:0]   dy;
	logic signed [ggs_pkg::XW-1:0] x0;
	logic signed [ggs_pkg::XW-1:0] y0;

	always_comb begin
		dx = $signed({1'b0, cfg_regs.goal_x}) - $signed({1'b0, pose.pose_x});
		dy = $signed({1'b0, cfg_regs.goal_y}) - $signed({1'b0, pose.pose_y});
		// scale to units of 2^-20
		x0 = $signed({{PAD{dx[POS_W_P]}}, dx, 8'b0});
		y0 = $signed({{PAD{dy[POS_W_P]}}, dy, 8'b0});
		nxt.head = pose.heading;
		if (dx[POS_W_P]) begin
			nxt.x = -x0;
			nxt.y = -y0;
			nxt.z = ggs_pkg::ANG_PI;
		end else begin
			nxt.x = x0;
			nxt.y = y0;
			nxt.z = '0;
		end
	end

	assign pose.ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pose.ready) begin
			valid_q <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pose.ready && pose.valid) begin
			word_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
endmodule

[hw/rtl/ggs_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ggs_cordic_cell
// one vectoring micro-rotation with its own word register and handshake
// ----------------------------------------------------------------------------
module ggs_cordic_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ggs_pkg::SIW-1:0]    stage,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ggs_pkg::cordic_word_t      in_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ggs_pkg::cordic_word_t      out_word
);
	logic                          valid_q;
	ggs_pkg::cordic_word_t         word_q;
	ggs_pkg::cordic_word_t         nxt;
	logic signed [ggs_pkg::XW-1:0] xs;
	logic signed [ggs_pkg::XW-1:0] ys;
	logic signed [ggs_pkg::ZW-1:0] ang;

	always_comb begin
		// floor shifts
		xs  = in_word.x >>> stage;
		ys  = in_word.y >>> stage;
		ang = $signed(ggs_pkg::atan_lut(stage));
		nxt.head = in_word.head;
		if (in_word.y > 0) begin
			nxt.x = in_word.x + ys;
			nxt.y = in_word.y - xs;
			nxt.z = in_word.z + ang;
		end else begin
			nxt.x = in_word.x - ys;
			nxt.y = in_word.y + xs;
			nxt.z = in_word.z - ang;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
endmodule

[hw/rtl/ggs_scale.sv]
// ----------------------------------------------------------------------------
// ggs_scale
// cordic gain removal and heading error wrap
// ----------------------------------------------------------------------------
module ggs_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ggs_pkg::cordic_word_t in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ggs_pkg::steer_word_t  out_word
);
	localparam int PW   = ggs_pkg::XW - 1 + 16;
	localparam int ZPAD = ggs_pkg::EW - ggs_pkg::ZW;
	localparam int HPAD = ggs_pkg::EW - ggs_pkg::HEAD_W - 8;

	logic                          valid_q;
	ggs_pkg::steer_word_t          word_q;
	ggs_pkg::steer_word_t          nxt;
	logic [PW-1:0]                 prod;
	logic signed [ggs_pkg::EW-1:0] err_raw;
	logic signed [ggs_pkg::EW-1:0] err_wrap;
	logic signed [ggs_pkg::EW-1:0] err_abs;

	always_comb begin
		// x never goes negative in vectoring mode
		prod         = PW'(in_word.x[ggs_pkg::XW-2:0]) * PW'(ggs_pkg::INV_GAIN);
		nxt.distance = prod[16 +: ggs_pkg::DW];

		err_raw = $signed({{ZPAD{in_word.z[ggs_pkg::ZW-1]}}, in_word.z})
			- $signed({{HPAD{in_word.head[ggs_pkg::HEAD_W-1]}}, in_word.head, 8'b0});
		// one turn of correction covers the whole range
		if (err_raw >= ggs_pkg::ERR_PI) begin
			err_wrap = err_raw - ggs_pkg::ERR_2PI;
		end else if (err_raw < -ggs_pkg::ERR_PI) begin
			err_wrap = err_raw + ggs_pkg::ERR_2PI;
		end else begin
			err_wrap = err_raw;
		end
		err_abs = err_wrap[ggs_pkg::EW-1] ? -err_wrap : err_wrap;
		nxt.mag = err_abs[ggs_pkg::MW-1:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
endmodule

[hw/rtl/ggs_decide.sv]
// ----------------------------------------------------------------------------
// ggs_decide
// stop / turn / drive selection and the output word register
// ----------------------------------------------------------------------------
module ggs_decide (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ggs_pkg::cfg_regs_t   cfg_regs,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ggs_pkg::steer_word_t in_word,
	ggs_cmd_if.source            cmd
);
	localparam int PW = ggs_pkg::DW + ggs_pkg::CFG_DW;
	localparam int FW = PW - 20;

	logic                        valid_q;
	logic [ggs_pkg::FWD_W-1:0]   fwd_q;
	logic [ggs_pkg::TURN_W-1:0]  turn_q;
	logic [ggs_pkg::FWD_W-1:0]   fwd_nxt;
	logic [ggs_pkg::TURN_W-1:0]  turn_nxt;
	logic [PW-1:0]               prod;
	logic [FW-1:0]               fwd_full;
	logic [ggs_pkg::MW:0]        mag_rnd;

	always_comb begin
		prod     = PW'(in_word.distance) * PW'(cfg_regs.speed_gain);
		fwd_full = prod[PW-1:20];
		mag_rnd  = {1'b0, in_word.mag} + {1'b0, ggs_pkg::TURN_RND};
		fwd_nxt  = '0;
		turn_nxt = '0;
		if (in_word.distance > ggs_pkg::DIST_MIN) begin
			if (in_word.mag > ggs_pkg::ERR_MIN) begin
				turn_nxt = mag_rnd[8 +: ggs_pkg::TURN_W];
			end else if (fwd_full > FW'(cfg_regs.speed_limit)) begin
				fwd_nxt = cfg_regs.speed_limit;
			end else begin
				fwd_nxt = fwd_full[ggs_pkg::FWD_W-1:0];
			end
		end
	end

	assign in_ready = !valid_q || cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			fwd_q  <= fwd_nxt;
			turn_q <= turn_nxt;
		end
	end

	assign cmd.valid         = valid_q;
	assign cmd.forward_speed = fwd_q;
	assign cmd.turn_rate     = turn_q;
endmodule

[hw/rtl/go_to_goal_steering_top.sv]
// ----------------------------------------------------------------------------
// go_to_goal_steering_top
// proportional go-to-goal steering: one velocity command word per pose word
// ----------------------------------------------------------------------------
// Each pose word (x, y, heading) yields one command word toward the goal held
// in the configuration registers. The vector goal - pose runs down a chain of
// CORDIC_STAGES vectoring cells, one micro-rotation and one register per cell,
// which gives distance and bearing; then a cell removes the cordic gain and
// wraps bearing minus heading into [-pi, pi), and a last cell picks the command:
// both zero within 0.1 of the goal, a pure turn at the error magnitude above
// 0.2 rad, else forward speed gain * distance capped at speed_limit. A new pose
// word is taken every cycle unless a stalled command output has filled the
// chain. Every cell has its own valid bit and ready passes back along the
// chain, so a stalled output fills the empty slots before pose.ready drops.
// Configuration writes are always taken (cfg.ready is high); indexes beyond
// speed_limit are ignored. Registers must only be written while no pose is in
// flight.
// ----------------------------------------------------------------------------
module go_to_goal_steering_top (
	input  logic      clk,
	input  logic      arst_n,
	ggs_cfg_if.sink   cfg,
	ggs_pose_if.sink  pose,
	ggs_cmd_if.source cmd
);
	localparam int N = ggs_pkg::CORDIC_STAGES;

	// configuration registers
	ggs_pkg::cfg_regs_t    cfg_regs_q;

	// cell chain: slot 0 is the front register, slot N the last cell
	logic                  chain_valid [N+1];
	logic                  chain_ready [N+1];
	ggs_pkg::cordic_word_t chain_word  [N+1];

	// after gain removal
	logic                  steer_valid;
	logic                  steer_ready;
	ggs_pkg::steer_word_t  steer_word;

	// register writes, never back-pressured
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.goal_x      <= ggs_pkg::GOAL_X_RST;
			cfg_regs_q.goal_y      <= ggs_pkg::GOAL_Y_RST;
			cfg_regs_q.speed_gain  <= ggs_pkg::SPEED_GAIN_RST;
			cfg_regs_q.speed_limit <= ggs_pkg::SPEED_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				ggs_pkg::REG_GOAL_X:      cfg_regs_q.goal_x      <= cfg.data;
				ggs_pkg::REG_GOAL_Y:      cfg_regs_q.goal_y      <= cfg.data;
				ggs_pkg::REG_SPEED_GAIN:  cfg_regs_q.speed_gain  <= cfg.data;
				ggs_pkg::REG_SPEED_LIMIT: cfg_regs_q.speed_limit <= cfg.data;
				default: ; // unknown index: write dropped
			endcase
		end
	end

	// difference vector and half-plane move
	ggs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pose      (pose),
		.cfg_regs  (cfg_regs_q),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	// vectoring cells, cell i shifts by i
	for (genvar i = 0; i < N; i++) begin : g_cell
		ggs_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage     (ggs_pkg::SIW'(i)),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	// gain removal and error wrap
	ggs_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[N]),
		.in_ready  (chain_ready[N]),
		.in_word   (chain_word[N]),
		.out_valid (steer_valid),
		.out_ready (steer_ready),
		.out_word  (steer_word)
	);

	// command selection and output word
	ggs_decide u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs_q),
		.in_valid (steer_valid),
		.in_ready (steer_ready),
		.in_word  (steer_word),
		.cmd      (cmd)
	);
endmodule

[hw/rtl/ggs_checker.sv]
// ----------------------------------------------------------------------------
// ggs_checker
// port-level checks of the steering block, bound to the top level
// ----------------------------------------------------------------------------
module ggs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [ggs_pkg::CFG_IW-1:0]  cfg_index,
	input logic [ggs_pkg::CFG_DW-1:0]  cfg_data,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic [ggs_pkg::FWD_W-1:0]   cmd_forward_speed,
	input logic [ggs_pkg::TURN_W-1:0]  cmd_turn_rate
);
	// shadow of the speed limit register
	logic [ggs_pkg::CFG_DW-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ggs_pkg::SPEED_LIMIT_RST;
		end else if (cfg_valid && cfg_ready && cfg_index == ggs_pkg::REG_SPEED_LIMIT) begin
			limit_q <= cfg_data;
		end
	end

	// stalled command word holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_forward_speed)
			&& $stable(cmd_turn_rate))
		else $error("command word changed while stalled");

	// never drive and turn at once
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd_forward_speed == '0 || cmd_turn_rate == '0)
		else $error("forward speed and turn rate both nonzero");

	// turn rate bounded by pi
	a_turn_max: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd_turn_rate <= ggs_pkg::TURN_W'(12868))
		else $error("turn rate above pi");

	// forward speed capped
	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd_forward_speed <= limit_q)
		else $error("forward speed above speed limit");
endmodule

bind go_to_goal_steering_top ggs_checker u_ggs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cfg_valid         (cfg.valid),
	.cfg_ready         (cfg.ready),
	.cfg_index         (cfg.index),
	.cfg_data          (cfg.data),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.cmd_forward_speed (cmd.forward_speed),
	.cmd_turn_rate     (cmd.turn_rate)
);
